FILE: sv/slr_pkg.sv
// Shared widths, types and helper functions for the segment line reflection pipeline.
package slr_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int EPS_W = 16;
  localparam int TAG_W = 8;
  localparam int NLANE = 4;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DOT_W = PROD_W + 1;
  localparam int DEN_W = PROD_W;
  localparam int NCHUNK = 3;
  localparam int CHUNK_W = (DOT_W + NCHUNK - 1) / NCHUNK;
  localparam int PP_W = CHUNK_W + DIFF_W;
  localparam int NUM_W = DOT_W + DIFF_W + 1;
  localparam int QB = COORD_WIDTH + 4;
  localparam int REM_W = DEN_W + 1;
  localparam int SUM_W = QB + 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DOT_W-1:0] dot_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t COORD_MAX = {{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam sum_t COORD_MIN = {{(SUM_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

  typedef enum logic [1:0] {
    ST_REFLECTED  = 2'd0,
    ST_EQUAL      = 2'd1,
    ST_DEGENERATE = 2'd2,
    ST_SATURATED  = 2'd3
  } status_t;

  typedef struct packed {
    coord_t mx0;
    coord_t my0;
    coord_t sx0;
    coord_t sy0;
    coord_t sx1;
    coord_t sy1;
    logic [TAG_W-1:0] tag;
    logic eq;
    logic deg;
  } side_t;

  function automatic diff_t sx(input coord_t a);
    return {a[COORD_WIDTH-1], a};
  endfunction

  function automatic logic [DIFF_W-1:0] absd(input diff_t a);
    return a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
  endfunction

endpackage

FILE: sv/slr_front.sv
// Front pipeline: differences, products, dot products and divider numerators.
module slr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  slr_pkg::coord_t               mx0,
  input  slr_pkg::coord_t               my0,
  input  slr_pkg::coord_t               mx1,
  input  slr_pkg::coord_t               my1,
  input  slr_pkg::coord_t               psx0,
  input  slr_pkg::coord_t               psy0,
  input  slr_pkg::coord_t               psx1,
  input  slr_pkg::coord_t               psy1,
  input  logic [slr_pkg::TAG_W-1:0]     tag,
  input  logic [slr_pkg::EPS_W-1:0]     eps,
  output logic                          out_valid,
  output slr_pkg::side_t                out_side,
  output logic [slr_pkg::DEN_W-1:0]     out_den,
  output logic [slr_pkg::NUM_W-1:0]     out_num [slr_pkg::NLANE],
  output logic [slr_pkg::NLANE-1:0]     out_neg
);
  import slr_pkg::*;

  logic v1, v2, v3, v4, v5;
  side_t side1, side2, side3, side4, side5;
  side_t side1f;

  diff_t dx1, dy1;
  diff_t pu1 [2];
  diff_t pv1 [2];
  diff_t e1 [4];

  prod_t sq2 [2];
  prod_t pa2 [2];
  prod_t pb2 [2];
  logic [DIFF_W-1:0] mag2 [2];
  logic [1:0] sgn2;

  logic [DEN_W-1:0] den3;
  dot_t dot3 [2];
  logic [DIFF_W-1:0] mag3 [2];
  logic [1:0] sgn3;

  logic [DEN_W-1:0] den4;
  logic [NCHUNK*CHUNK_W-1:0] dm4 [2];
  logic [DIFF_W-1:0] mag4 [2];
  logic [NLANE-1:0] neg4;

  logic [DEN_W-1:0] den5;
  logic [PP_W-1:0] pp5 [NLANE][NCHUNK];
  logic [NLANE-1:0] neg5;

  logic [NUM_W-1:0] acc [NLANE];
  logic eq_c;
  logic deg_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    side1.mx0 <= mx0;
    side1.my0 <= my0;
    side1.sx0 <= psx0;
    side1.sy0 <= psy0;
    side1.sx1 <= psx1;
    side1.sy1 <= psy1;
    side1.tag <= tag;
    side1.eq <= 1'b0;
    side1.deg <= 1'b0;
    dx1 <= sx(mx1) - sx(mx0);
    dy1 <= sx(my1) - sx(my0);
    pu1[0] <= sx(psx0) - sx(mx0);
    pv1[0] <= sx(psy0) - sx(my0);
    pu1[1] <= sx(psx1) - sx(mx0);
    pv1[1] <= sx(psy1) - sx(my0);
    e1[0] <= sx(mx0) - sx(psx0);
    e1[1] <= sx(my0) - sx(psy0);
    e1[2] <= sx(mx1) - sx(psx1);
    e1[3] <= sx(my1) - sx(psy1);
  end

  always_comb begin
    eq_c = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (absd(e1[i]) >= DIFF_W'(eps)) begin
        eq_c = 1'b0;
      end
    end
    deg_c = !eq_c && (absd(dx1) <= DIFF_W'(eps)) && (absd(dy1) <= DIFF_W'(eps));
    side1f = side1;
    side1f.eq = eq_c;
    side1f.deg = deg_c;
  end

  always_ff @(posedge clk) begin
    side2 <= side1f;
    sq2[0] <= dx1 * dx1;
    sq2[1] <= dy1 * dy1;
    for (int p = 0; p < 2; p++) begin
      pa2[p] <= pu1[p] * dx1;
      pb2[p] <= pv1[p] * dy1;
    end
    mag2[0] <= absd(dx1);
    mag2[1] <= absd(dy1);
    sgn2 <= {dy1[DIFF_W-1], dx1[DIFF_W-1]};
  end

  always_ff @(posedge clk) begin
    side3 <= side2;
    den3 <= DEN_W'(sq2[0] + sq2[1]);
    for (int p = 0; p < 2; p++) begin
      dot3[p] <= dot_t'(pa2[p]) + dot_t'(pb2[p]);
      mag3[p] <= mag2[p];
    end
    sgn3 <= sgn2;
  end

  always_ff @(posedge clk) begin
    side4 <= side3;
    den4 <= den3;
    for (int p = 0; p < 2; p++) begin
      dm4[p] <= (NCHUNK*CHUNK_W)'(dot3[p][DOT_W-1] ? DOT_W'(-dot3[p]) : DOT_W'(dot3[p]));
      mag4[p] <= mag3[p];
    end
    for (int l = 0; l < NLANE; l++) begin
      neg4[l] <= dot3[l>>1][DOT_W-1] ^ sgn3[l&1];
    end
  end

  always_ff @(posedge clk) begin
    side5 <= side4;
    den5 <= den4;
    neg5 <= neg4;
    for (int l = 0; l < NLANE; l++) begin
      for (int k = 0; k < NCHUNK; k++) begin
        pp5[l][k] <= PP_W'(dm4[l>>1][k*CHUNK_W +: CHUNK_W]) * PP_W'(mag4[l&1]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      acc[l] = '0;
      for (int k = 0; k < NCHUNK; k++) begin
        acc[l] = acc[l] + (NUM_W'(pp5[l][k]) << (k * CHUNK_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    out_side <= side5;
    out_den <= den5;
    out_neg <= neg5;
    for (int l = 0; l < NLANE; l++) begin
      out_num[l] <= acc[l] << 1;
    end
  end

endmodule

FILE: sv/slr_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes sharing one divisor.
module slr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  slr_pkg::side_t                in_side,
  input  logic [slr_pkg::DEN_W-1:0]     in_den,
  input  logic [slr_pkg::NUM_W-1:0]     in_num [slr_pkg::NLANE],
  input  logic [slr_pkg::NLANE-1:0]     in_neg,
  output logic                          out_valid,
  output slr_pkg::side_t                out_side,
  output logic [slr_pkg::DEN_W-1:0]     out_den,
  output logic [slr_pkg::QB-1:0]        out_q [slr_pkg::NLANE],
  output logic [slr_pkg::REM_W-1:0]     out_rem [slr_pkg::NLANE],
  output logic [slr_pkg::NLANE-1:0]     out_neg
);
  import slr_pkg::*;

  logic vld [QB+1];
  side_t sd [QB+1];
  logic [DEN_W-1:0] den [QB+1];
  logic [NLANE-1:0] neg [QB+1];
  logic [REM_W-1:0] rem [QB+1][NLANE];
  logic [QB-1:0] low [QB+1][NLANE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sd[0] <= in_side;
    den[0] <= in_den;
    neg[0] <= in_neg;
    for (int l = 0; l < NLANE; l++) begin
      rem[0][l] <= REM_W'(in_num[l] >> QB);
      low[0][l] <= in_num[l][QB-1:0];
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [REM_W-1:0] trial [NLANE];
    logic [NLANE-1:0] ge;

    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        trial[l] = {rem[i][l][REM_W-2:0], low[i][l][QB-1]};
        ge[l] = trial[l] >= REM_W'(den[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      sd[i+1] <= sd[i];
      den[i+1] <= den[i];
      neg[i+1] <= neg[i];
      for (int l = 0; l < NLANE; l++) begin
        rem[i+1][l] <= ge[l] ? trial[l] - REM_W'(den[i]) : trial[l];
        low[i+1][l] <= {low[i][l][QB-2:0], ge[l]};
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_side = sd[QB];
  assign out_den = den[QB];
  assign out_neg = neg[QB];
  assign out_q = low[QB];
  assign out_rem = rem[QB];

endmodule

FILE: sv/slr_back.sv
// Back pipeline: rounding, reconstruction of the reflected points, saturation and status.
module slr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  slr_pkg::side_t                in_side,
  input  logic [slr_pkg::DEN_W-1:0]     in_den,
  input  logic [slr_pkg::QB-1:0]        in_q [slr_pkg::NLANE],
  input  logic [slr_pkg::REM_W-1:0]     in_rem [slr_pkg::NLANE],
  input  logic [slr_pkg::NLANE-1:0]     in_neg,
  output logic                          done,
  output slr_pkg::coord_t               refl_x0,
  output slr_pkg::coord_t               refl_y0,
  output slr_pkg::coord_t               refl_x1,
  output slr_pkg::coord_t               refl_y1,
  output logic [1:0]                    status,
  output logic [slr_pkg::TAG_W-1:0]     tag_out
);
  import slr_pkg::*;

  logic v1, v2;
  side_t side1, side2;
  logic [QB:0] qr1 [NLANE];
  logic [NLANE-1:0] neg1;
  sum_t r2 [NLANE];
  coord_t base_a [NLANE];
  coord_t base_p [NLANE];
  sum_t c2 [NLANE];
  coord_t sat_v [NLANE];
  logic [NLANE-1:0] sat_f;
  status_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    side1 <= in_side;
    neg1 <= in_neg;
    for (int l = 0; l < NLANE; l++) begin
      qr1[l] <= (QB+1)'(in_q[l])
        + (QB+1)'({in_rem[l], 1'b0} >= (REM_W+1)'(in_den));
    end
  end

  always_comb begin
    base_a[0] = side1.mx0;
    base_p[0] = side1.sx0;
    base_a[1] = side1.my0;
    base_p[1] = side1.sy0;
    base_a[2] = side1.mx0;
    base_p[2] = side1.sx1;
    base_a[3] = side1.my0;
    base_p[3] = side1.sy1;
    for (int l = 0; l < NLANE; l++) begin
      c2[l] = neg1[l] ? -sum_t'({1'b0, qr1[l]}) : sum_t'({1'b0, qr1[l]});
    end
  end

  always_ff @(posedge clk) begin
    side2 <= side1;
    for (int l = 0; l < NLANE; l++) begin
      r2[l] <= (sum_t'(base_a[l]) <<< 1) - sum_t'(base_p[l]) + c2[l];
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (r2[l] > COORD_MAX) begin
        sat_v[l] = COORD_MAX[COORD_WIDTH-1:0];
        sat_f[l] = 1'b1;
      end else if (r2[l] < COORD_MIN) begin
        sat_v[l] = COORD_MIN[COORD_WIDTH-1:0];
        sat_f[l] = 1'b1;
      end else begin
        sat_v[l] = r2[l][COORD_WIDTH-1:0];
        sat_f[l] = 1'b0;
      end
    end
    priority if (side2.eq) begin
      st = ST_EQUAL;
    end else if (side2.deg) begin
      st = ST_DEGENERATE;
    end else if (|sat_f) begin
      st = ST_SATURATED;
    end else begin
      st = ST_REFLECTED;
    end
  end

  always_ff @(posedge clk) begin
    tag_out <= side2.tag;
    status <= st;
    if (side2.eq || side2.deg) begin
      refl_x0 <= side2.sx0;
      refl_y0 <= side2.sy0;
      refl_x1 <= side2.sx1;
      refl_y1 <= side2.sy1;
    end else begin
      refl_x0 <= sat_v[0];
      refl_y0 <= sat_v[1];
      refl_x1 <= sat_v[2];
      refl_y1 <= sat_v[3];
    end
  end

endmodule

FILE: sv/segment_line_reflection.sv
// Top level of the segment line reflection pipeline.
// Reflects both endpoints of a segment across the line through two mirror points.
// Input: a word is taken at a rising edge where start is high and busy is low;
// it carries the mirror endpoints, the segment endpoints and a mirror tag.
// Output: done is high for one cycle with refl_x0..refl_y1, status and tag_out;
// the receiver cannot hold results off, so the pipeline never stalls.
// Configuration: cfg_we writes cfg_wdata into the eps tolerance, which resets to 1;
// write it only while no word is in flight.
// Pipeline: six front stages (differences, products, dot sums, magnitudes, partial
// products, numerator), a divider input register and one divider stage per quotient
// bit (QB of them), and three back stages (rounding, sum, saturation).
// Throughput: one word per cycle whenever busy is low; the divider lanes are fully pipelined.
// Reset: rst is synchronous; it clears all valid bits and sets busy high, which
// drops at the first clock edge that samples rst low.
module segment_line_reflection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [slr_pkg::EPS_W-1:0]     cfg_wdata,
  input  slr_pkg::coord_t               mirror_x0,
  input  slr_pkg::coord_t               mirror_y0,
  input  slr_pkg::coord_t               mirror_x1,
  input  slr_pkg::coord_t               mirror_y1,
  input  slr_pkg::coord_t               seg_x0,
  input  slr_pkg::coord_t               seg_y0,
  input  slr_pkg::coord_t               seg_x1,
  input  slr_pkg::coord_t               seg_y1,
  input  logic [slr_pkg::TAG_W-1:0]     mirror_tag,
  output logic                          done,
  output slr_pkg::coord_t               refl_x0,
  output slr_pkg::coord_t               refl_y0,
  output slr_pkg::coord_t               refl_x1,
  output slr_pkg::coord_t               refl_y1,
  output logic [1:0]                    status,
  output logic [slr_pkg::TAG_W-1:0]     tag_out
);
  import slr_pkg::*;

  logic [EPS_W-1:0] eps_tolerance;
  logic accept;

  logic f_valid;
  side_t f_side;
  logic [DEN_W-1:0] f_den;
  logic [NUM_W-1:0] f_num [NLANE];
  logic [NLANE-1:0] f_neg;

  logic d_valid;
  side_t d_side;
  logic [DEN_W-1:0] d_den;
  logic [QB-1:0] d_q [NLANE];
  logic [REM_W-1:0] d_rem [NLANE];
  logic [NLANE-1:0] d_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps_tolerance <= EPS_W'(1);
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        eps_tolerance <= cfg_wdata;
      end
    end
  end

  assign accept = start && !busy;

  slr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .mx0       (mirror_x0),
    .my0       (mirror_y0),
    .mx1       (mirror_x1),
    .my1       (mirror_y1),
    .psx0      (seg_x0),
    .psy0      (seg_y0),
    .psx1      (seg_x1),
    .psy1      (seg_y1),
    .tag       (mirror_tag),
    .eps       (eps_tolerance),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_den   (f_den),
    .out_num   (f_num),
    .out_neg   (f_neg)
  );

  slr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .in_den    (f_den),
    .in_num    (f_num),
    .in_neg    (f_neg),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_den   (d_den),
    .out_q     (d_q),
    .out_rem   (d_rem),
    .out_neg   (d_neg)
  );

  slr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_side  (d_side),
    .in_den   (d_den),
    .in_q     (d_q),
    .in_rem   (d_rem),
    .in_neg   (d_neg),
    .done     (done),
    .refl_x0  (refl_x0),
    .refl_y0  (refl_y0),
    .refl_x1  (refl_x1),
    .refl_y1  (refl_y1),
    .status   (status),
    .tag_out  (tag_out)
  );

endmodule
